// ===== rtl/core/ldp_pkg.sv =====
package ldp_pkg;

    localparam int LANES       = 4;
    localparam int OP_W        = 16;
    localparam int PROD_W      = 2 * OP_W;
    localparam int SUM_W       = 48;
    localparam int CNT_W       = 16;
    localparam int MAX_VECTORS = ((1 << CNT_W) - 2) / LANES + 1;
    localparam int IDX_W       = (MAX_VECTORS > 1) ? $clog2(MAX_VECTORS) : 1;
    localparam int TREE_LVL    = $clog2(LANES);
    localparam int TREE_LEAVES = 1 << TREE_LVL;
    localparam int TREE_NODES  = 2 * TREE_LEAVES - 1;
    localparam int OFS_W       = CNT_W + 1;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic             REG_ELEMENT_COUNT = 1'b0;
    localparam logic [CNT_W-1:0] COUNT_RESET       = CNT_W'(1);

    typedef struct packed {
        logic prod_en;
        logic keep;
        logic acc_en;
        logic acc_clr;
    } t_lane_ctl;

endpackage

// ===== rtl/core/lane_parallel_dot_product.sv =====
// Streaming dot product over signed Q4.12 vectors, four elements of x and y
// per transaction. Each lane multiplies its pair and accumulates a 48-bit
// sum; after ceil(element_count/4) transactions the lane sums are merged
// into one signed Q24.24 result on o_dot_value, exact for up to 65535
// elements, and the accumulators restart. A transaction is taken every
// cycle; the only backpressure is a finished product waiting on a full
// merge tree. The last transaction passes one product register, then the
// registered adder tree (leaf, inner and root levels), fed by the lane
// accumulator adders. element_count lives at address 0; the user must
// write it only between products; the block does not enforce it. A count
// of zero takes each transaction as a complete product with result zero.
module lane_parallel_dot_product (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic        [ldp_pkg::PADDR_W-1:0]  paddr,
    input  logic        [ldp_pkg::PDATA_W-1:0]  pwdata,
    output logic        [ldp_pkg::PDATA_W-1:0]  prdata,
    output logic                                pready,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_x_lane0,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_x_lane1,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_x_lane2,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_x_lane3,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_y_lane0,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_y_lane1,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_y_lane2,
    input  logic signed [ldp_pkg::OP_W-1:0]     i_y_lane3,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [ldp_pkg::SUM_W-1:0]    o_dot_value
);
    import ldp_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic [IDX_W-1:0] n_idx;
    logic [IDX_W-1:0] last_idx;
    logic [CNT_W-1:0] cnt_m1;
    logic [OFS_W-1:0] base;
    logic             in_last;
    logic             accept;
    logic             cfg_wr;

    logic             r_a_valid;
    logic             r_a_last;
    logic             ready_a;
    logic             adv_a;
    logic             merge_ready;
    logic [SUM_W-1:0] merge_sum;

    logic signed [OP_W-1:0]  x_in [4];
    logic signed [OP_W-1:0]  y_in [4];
    logic        [SUM_W-1:0] lane_total [LANES];
    t_lane_ctl               lane_ctl [LANES];

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_ELEMENT_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (cfg_wr) begin
            r_count <= pwdata[CNT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_ELEMENT_COUNT) begin
            prdata = PDATA_W'(r_count);
        end
    end

    // vector bookkeeping
    assign cnt_m1   = r_count - CNT_W'(1);
    assign last_idx = (r_count == '0) ? '0 : IDX_W'(cnt_m1 / CNT_W'(LANES));
    assign in_last  = (r_idx >= last_idx);
    assign base     = OFS_W'(r_idx) * OFS_W'(LANES);
    assign n_idx    = in_last ? '0 : r_idx + IDX_W'(1);

    assign ready_a    = !r_a_valid || !r_a_last || merge_ready;
    assign adv_a      = r_a_valid && ready_a;
    assign o_in_stall = !ready_a;
    assign accept     = i_in_valid && ready_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= '0;
            r_a_valid <= 1'b0;
            r_a_last  <= 1'b0;
        end else begin
            if (accept) begin
                r_idx    <= n_idx;
                r_a_last <= in_last;
            end
            if (accept) begin
                r_a_valid <= 1'b1;
            end else if (adv_a) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // lanes
    assign x_in[0] = i_x_lane0;
    assign x_in[1] = i_x_lane1;
    assign x_in[2] = i_x_lane2;
    assign x_in[3] = i_x_lane3;
    assign y_in[0] = i_y_lane0;
    assign y_in[1] = i_y_lane1;
    assign y_in[2] = i_y_lane2;
    assign y_in[3] = i_y_lane3;

    genvar j;
    generate
        for (j = 0; j < LANES; j++) begin : g_lane
            assign lane_ctl[j].prod_en = accept;
            assign lane_ctl[j].keep    = (base + OFS_W'(j)) < OFS_W'(r_count);
            assign lane_ctl[j].acc_en  = adv_a;
            assign lane_ctl[j].acc_clr = r_a_last;

            ldp_lane u_lane (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_x     (x_in[j]),
                .i_y     (y_in[j]),
                .i_ctl   (lane_ctl[j]),
                .o_total (lane_total[j])
            );
        end
    endgenerate

    ldp_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (adv_a && r_a_last),
        .i_sums  (lane_total),
        .o_ready (merge_ready),
        .o_valid (o_out_valid),
        .o_sum   (merge_sum),
        .i_stall (i_out_stall)
    );

    assign o_dot_value = $signed(merge_sum);

    // checks
    a_hold_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid && r_a_last && !merge_ready |=> r_a_valid && r_a_last)
        else $error("finished product dropped while merge tree full");

    a_idx_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && in_last |=> r_idx == '0)
        else $error("vector index not cleared after last vector");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_a_valid && r_a_last)
        else $error("input stalled without a pending final vector");

endmodule

// ===== rtl/core/ldp_lane.sv =====
module ldp_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic signed [ldp_pkg::OP_W-1:0]   i_x,
    input  logic signed [ldp_pkg::OP_W-1:0]   i_y,
    input  ldp_pkg::t_lane_ctl                i_ctl,
    output logic        [ldp_pkg::SUM_W-1:0]  o_total
);
    import ldp_pkg::*;

    logic signed [PROD_W-1:0] r_prod;
    logic        [SUM_W-1:0]  r_sum;
    logic        [SUM_W-1:0]  n_sum;

    // product stage, masked lanes contribute zero
    always_ff @(posedge i_clk) begin
        if (i_ctl.prod_en) begin
            r_prod <= i_ctl.keep ? PROD_W'(i_x * i_y) : '0;
        end
    end

    assign n_sum   = r_sum + SUM_W'(r_prod);
    assign o_total = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.acc_en) begin
            r_sum <= i_ctl.acc_clr ? '0 : n_sum;
        end
    end

endmodule

// ===== rtl/core/ldp_merge.sv =====
module ldp_merge (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  logic [ldp_pkg::SUM_W-1:0]     i_sums [ldp_pkg::LANES],
    output logic                          o_ready,
    output logic                          o_valid,
    output logic [ldp_pkg::SUM_W-1:0]     o_sum,
    input  logic                          i_stall
);
    import ldp_pkg::*;

    logic [SUM_W-1:0]  r_node [TREE_NODES];
    logic [TREE_LVL:0] r_vld;
    logic [TREE_LVL:0] n_vld;
    logic [TREE_LVL:0] rdy;
    logic [TREE_LVL:0] pop;
    logic [TREE_LVL:0] load;

    // depth 0 is the root and output register, depth TREE_LVL the leaves
    genvar d, i;
    generate
        for (d = 0; d <= TREE_LVL; d++) begin : g_depth
            if (d == 0) begin : g_root
                assign rdy[d] = !r_vld[d] || !i_stall;
                assign pop[d] = r_vld[d] && !i_stall;
            end else begin : g_inner
                assign rdy[d] = !r_vld[d] || rdy[d-1];
                assign pop[d] = r_vld[d] && rdy[d-1];
            end
            if (d == TREE_LVL) begin : g_leaf_load
                assign load[d] = i_valid;
            end else begin : g_node_load
                assign load[d] = pop[d+1];
            end
            assign n_vld[d] = load[d] || (r_vld[d] && !pop[d]);

            for (i = 0; i < (1 << d); i++) begin : g_node
                localparam int K = (1 << d) - 1 + i;
                if (d == TREE_LVL) begin : g_leaf
                    if (i < LANES) begin : g_used
                        always_ff @(posedge i_clk) begin
                            if (load[d]) begin
                                r_node[K] <= i_sums[i];
                            end
                        end
                    end else begin : g_pad
                        always_ff @(posedge i_clk) begin
                            if (load[d]) begin
                                r_node[K] <= '0;
                            end
                        end
                    end
                end else begin : g_add
                    always_ff @(posedge i_clk) begin
                        if (load[d]) begin
                            r_node[K] <= r_node[2*K+1] + r_node[2*K+2];
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ready = rdy[TREE_LVL];
    assign o_valid = r_vld[0];
    assign o_sum   = r_node[0];

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ldp_pkg::*;

    localparam int LATENCY        = 2 + TREE_LVL;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int MAX_REPORTS    = 100;
    localparam logic [PADDR_W-1:0] ADDR_ELEMENT_COUNT = PADDR_W'(4 * REG_ELEMENT_COUNT);

    typedef logic signed [OP_W-1:0]  t_op;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef struct {
        t_op x[LANES];
        t_op y[LANES];
    } t_vec_item;

    class t_dot_checker;
        logic [CNT_W-1:0] elem_count;
        t_sum             lane_sums[LANES];
        int unsigned      vec_idx;
        t_sum             pending_dots[$];
        int unsigned      vectors_seen;
        int unsigned      dots_checked;

        function new();
            elem_count   = COUNT_RESET;
            vectors_seen = 0;
            dots_checked = 0;
            clear();
        endfunction

        function void clear();
            foreach (lane_sums[j]) lane_sums[j] = '0;
            vec_idx = 0;
        endfunction

        function void set_count(logic [CNT_W-1:0] n);
            elem_count = n;
        endfunction

        function int unsigned vectors_per_dot();
            return (elem_count == 0) ? 1 : (int'(elem_count) - 1) / LANES + 1;
        endfunction

        function void take_vector(t_vec_item it);
            int unsigned             base;
            logic signed [PROD_W-1:0] prod;
            t_sum                    total;
            base = vec_idx * LANES;
            vectors_seen++;
            for (int j = 0; j < LANES; j++) begin
                if (base + j < elem_count) begin
                    prod = it.x[j] * it.y[j];
                    lane_sums[j] = lane_sums[j] + prod;
                end
            end
            if (vec_idx + 1 >= vectors_per_dot()) begin
                total = '0;
                foreach (lane_sums[j]) total = total + lane_sums[j];
                pending_dots.push_back(total);
                clear();
            end else begin
                vec_idx++;
            end
        endfunction

        function string check_dot(t_sum got);
            t_sum want;
            if (pending_dots.size() == 0) begin
                return $sformatf("dot_value %0d with no product pending", got);
            end
            want = pending_dots.pop_front();
            dots_checked++;
            if (got !== want) begin
                return $sformatf("dot_value %0d, expected %0d", got, want);
            end
            return "";
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;
    logic                i_in_valid;
    logic                o_in_stall;
    t_op                 x_drv[LANES];
    t_op                 y_drv[LANES];
    logic                o_out_valid;
    logic                i_out_stall;
    t_sum                o_dot_value;

    t_dot_checker chk;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int holdoff_left   = 0;
    int errors         = 0;
    int quiet_cycles   = 0;
    int idle_set[4]    = '{0, 51, 0, 27};
    int stall_set[4]   = '{0, 0, 51, 27};

    lane_parallel_dot_product dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_x_lane0   (x_drv[0]),
        .i_x_lane1   (x_drv[1]),
        .i_x_lane2   (x_drv[2]),
        .i_x_lane3   (x_drv[3]),
        .i_y_lane0   (y_drv[0]),
        .i_y_lane1   (y_drv[1]),
        .i_y_lane2   (y_drv[2]),
        .i_y_lane3   (y_drv[3]),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_dot_value (o_dot_value)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task report_mismatch(string msg);
        if (errors < MAX_REPORTS) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
        errors++;
    endtask

    // receiver side: random stall, or a long hold-off when requested
    initial begin
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (holdoff_left > 0) begin
                i_out_stall <= 1'b1;
                holdoff_left--;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // results are checked before the input of the same edge is noted
    always @(posedge i_clk) begin : monitor
        string     msg;
        t_vec_item it;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                msg = chk.check_dot(o_dot_value);
                if (msg != "") report_mismatch(msg);
            end
            if (i_in_valid && !o_in_stall) begin
                foreach (it.x[j]) begin
                    it.x[j] = x_drv[j];
                    it.y[j] = y_drv[j];
                end
                chk.take_vector(it);
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= WATCHDOG_LIMIT) begin
                    $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                    $display("FAIL lane_parallel_dot_product");
                    $finish;
                end
            end
        end
    end

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (chk.pending_dots.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic program_count(int unsigned n);
        drain();
        apb_write(ADDR_ELEMENT_COUNT, PDATA_W'(n));
        chk.set_count(CNT_W'(n));
    endtask

    task automatic send_item(t_vec_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        foreach (it.x[j]) begin
            x_drv[j] <= it.x[j];
            y_drv[j] <= it.y[j];
        end
        do @(posedge i_clk); while (o_in_stall);
    endtask

    function automatic t_vec_item rand_item();
        t_vec_item it;
        foreach (it.x[j]) begin
            it.x[j] = OP_W'($urandom());
            it.y[j] = OP_W'($urandom());
        end
        return it;
    endfunction

    function automatic t_vec_item uniform(t_op xv, t_op yv);
        t_vec_item it;
        foreach (it.x[j]) begin
            it.x[j] = xv;
            it.y[j] = yv;
        end
        return it;
    endfunction

    function automatic int unsigned pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 25) return LANES * $urandom_range(1, 8);
        return $urandom_range(1, 40);
    endfunction

    // whole products only, so the block is between products afterwards
    task automatic send_products(int unsigned target_vectors);
        int unsigned vectors;
        int unsigned products;
        vectors  = chk.vectors_per_dot();
        products = (target_vectors + vectors - 1) / vectors;
        repeat (products * vectors) send_item(rand_item());
    endtask

    initial begin
        chk = new();
        i_rst_n    <= 1'b0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;
        i_in_valid <= 1'b0;
        foreach (x_drv[j]) begin
            x_drv[j] <= '0;
            y_drv[j] <= '0;
        end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // count left at its reset value
        send_item(uniform(16'sh7FFF, 16'sh7FFF));
        send_item(rand_item());

        // operand extremes, one vector per product
        program_count(LANES);
        send_item(uniform(-16'sh8000, -16'sh8000));
        send_item(uniform(16'sh7FFF, -16'sh8000));
        send_item(uniform(16'sh7FFF, 16'sh7FFF));
        send_item(uniform(-16'sh0001, -16'sh0001));

        // top lanes masked in the last vector
        program_count(LANES - 1);
        send_item(uniform(-16'sh8000, -16'sh8000));
        program_count(LANES + 1);
        send_item(uniform(16'sh7FFF, 16'sh7FFF));
        send_item(uniform(-16'sh8000, -16'sh8000));

        // zero count: every transaction is a product of zero
        program_count(0);
        repeat (3) send_item(rand_item());
        program_count(2 * LANES - 1);
        repeat (2) send_item(rand_item());

        for (int p = 0; p < 4; p++) begin
            send_idle_pct  = idle_set[p];
            recv_stall_pct = stall_set[p];
            repeat (6) begin
                program_count(pick_count());
                send_products(32);
            end
            if (p == 0) begin
                // long receiver hold-off so the block backs up into its input
                program_count(1);
                holdoff_left = HOLDOFF_CYCLES;
                repeat (40) send_item(rand_item());
            end
        end

        // longer product with the largest products in every lane
        program_count(16 * LANES);
        repeat (chk.vectors_per_dot()) send_item(uniform(-16'sh8000, -16'sh8000));
        drain();

        $display("covered %0d vector transactions and %0d dot products", chk.vectors_seen,
                 chk.dots_checked);
        $display("counts from 0 to 64, operand extremes, lane masking, idle and stall mixes");
        if (errors == 0) begin
            $display("PASS lane_parallel_dot_product");
        end else begin
            $display("%0d mismatches", errors);
            $display("FAIL lane_parallel_dot_product");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/ldp_pkg.sv
rtl/core/ldp_lane.sv
rtl/core/ldp_merge.sv
rtl/core/lane_parallel_dot_product.sv
tb/sv/tb_top.sv
